// ===== rtl/nos_pkg.sv =====
// ----------------------------------------------------------------------------
// nos_pkg - shared types and constants for the note-off scheduler
// Entry layout, table sizing, mode and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nos_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [6:0] RELEASE_VEL = 7'd64;

  localparam logic [7:0] NOTE_ON_RST  = 8'd1;
  localparam logic [7:0] NOTE_OFF_RST = 8'd2;

  typedef enum logic [1:0] {
    MODE_EVENT   = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_LOCATE  = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_NOTE_ON  = 1'b0,
    CFG_NOTE_OFF = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0] due_tick;
    logic [31:0] sink;
    logic [7:0]  note;
    logic [7:0]  chan;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/note_off_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// note_off_scheduler_core - pending note-off table
// Stores note-offs in a one-port-write / one-port-read table and emits
// the due ones on an advance, compacting the survivors in place.
// ----------------------------------------------------------------------------
// Timing: event and locate words are absorbed at accept; a drop word strobes
//   the cycle after accept. An advance holds busy while the table is scanned;
//   each due entry waits in hold_r and strobes once the next due entry is
//   checked, the final one (last = 1) in the first cycle with busy low.
// Throughput: one table entry per cycle during a scan (single read port).
// Reset: synchronous, active low; clears count and scan control; results
//   cannot stall. Table contents stay undefined.
`default_nettype none

module note_off_scheduler_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // command channel
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_mode,
  input  wire logic [63:0]   in_tick,
  input  wire logic [7:0]    in_payload_tag,
  input  wire logic [31:0]   in_duration,
  input  wire logic [31:0]   in_sink_id,
  input  wire logic [7:0]    in_note,
  input  wire logic [7:0]    in_channel,
  // result channel
  output logic               out_valid,
  output logic [63:0]        out_due_tick,
  output logic [31:0]        out_off_sink,
  output logic [7:0]         out_off_channel,
  output logic [7:0]         out_off_note,
  output logic [7:0]         out_off_tag,
  output logic [6:0]         out_velocity,
  output logic               out_dropped,
  output logic               out_last,
  // configuration
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire nos_pkg::cfg_idx_t cfg_index,
  input  wire logic [7:0]    cfg_data
);

  import nos_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  // table storage: written at one address, read registered at one address
  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // control
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;          // entries held
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;    // next entry to read
  logic [CNT_W-1:0] keep_r, keep_nxt;        // compaction write pointer
  logic             rd_pend_r, rd_pend_nxt;  // rd_data_r holds a fresh entry
  logic             hold_vld_r, hold_vld_nxt;
  entry_t           hold_r, hold_nxt;        // due entry waiting for its last flag
  logic [63:0]      tgt_r, tgt_nxt;          // advance target tick

  logic [7:0]       note_on_r, note_off_r;

  // result registers
  logic             out_valid_r, out_valid_nxt;
  entry_t           out_ent_r, out_ent_nxt;
  logic [7:0]       out_tag_r, out_tag_nxt;
  logic [6:0]       out_vel_r, out_vel_nxt;
  logic             out_drop_r, out_drop_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             issue;
  logic             due;
  entry_t           new_ent;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // incoming note-off: off time wraps modulo 2^64
  assign new_ent.due_tick = in_tick + {32'd0, in_duration};
  assign new_ent.sink     = in_sink_id;
  assign new_ent.note     = in_note;
  assign new_ent.chan     = in_channel;

  assign issue     = (rd_idx_r < cnt_r);
  assign mem_re    = (state_r == ST_SCAN) && issue;
  assign mem_raddr = rd_idx_r[IDX_W-1:0];
  assign due       = (rd_data_r.due_tick <= tgt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    keep_nxt      = keep_r;
    rd_pend_nxt   = 1'b0;
    hold_vld_nxt  = hold_vld_r;
    hold_nxt      = hold_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = 1'b0;
    out_ent_nxt   = out_ent_r;
    out_tag_nxt   = out_tag_r;
    out_vel_nxt   = out_vel_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[IDX_W-1:0];
    mem_wdata     = new_ent;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_t'(in_mode))
            MODE_EVENT: begin
              if (in_payload_tag == note_on_r && in_duration != 32'd0) begin
                if (cnt_r >= CNT_W'(CAPACITY)) begin
                  // table full: report the lost note
                  out_valid_nxt = 1'b1;
                  out_ent_nxt   = new_ent;
                  out_tag_nxt   = 8'd0;
                  out_vel_nxt   = 7'd0;
                  out_drop_nxt  = 1'b1;
                  out_last_nxt  = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
              end
            end
            MODE_ADVANCE: begin
              state_nxt    = ST_SCAN;
              tgt_nxt      = in_tick;
              rd_idx_nxt   = '0;
              keep_nxt     = '0;
              hold_vld_nxt = 1'b0;
            end
            MODE_LOCATE: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          if (due) begin
            // previous due entry is not the last one: release it now
            if (hold_vld_r) begin
              out_valid_nxt = 1'b1;
              out_ent_nxt   = hold_r;
              out_tag_nxt   = note_off_r;
              out_vel_nxt   = RELEASE_VEL;
              out_drop_nxt  = 1'b0;
              out_last_nxt  = 1'b0;
            end
            hold_vld_nxt = 1'b1;
            hold_nxt     = rd_data_r;
          end else begin
            // survivor moves down; keep_r never passes the read pointer
            mem_we    = 1'b1;
            mem_waddr = keep_r[IDX_W-1:0];
            mem_wdata = rd_data_r;
            keep_nxt  = keep_r + CNT_W'(1);
          end
        end else if (!issue) begin
          // scan drained
          if (hold_vld_r) begin
            out_valid_nxt = 1'b1;
            out_ent_nxt   = hold_r;
            out_tag_nxt   = note_off_r;
            out_vel_nxt   = RELEASE_VEL;
            out_drop_nxt  = 1'b0;
            out_last_nxt  = 1'b1;
          end
          hold_vld_nxt = 1'b0;
          cnt_nxt      = keep_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      keep_r      <= '0;
      rd_pend_r   <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      keep_r      <= keep_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    tgt_r      <= tgt_nxt;
    out_ent_r  <= out_ent_nxt;
    out_tag_r  <= out_tag_nxt;
    out_vel_r  <= out_vel_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_on_r  <= NOTE_ON_RST;
      note_off_r <= NOTE_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NOTE_ON:  note_on_r  <= cfg_data;
        CFG_NOTE_OFF: note_off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_due_tick    = out_ent_r.due_tick;
  assign out_off_sink    = out_ent_r.sink;
  assign out_off_channel = out_ent_r.chan;
  assign out_off_note    = out_ent_r.note;
  assign out_off_tag     = out_tag_r;
  assign out_velocity    = out_vel_r;
  assign out_dropped     = out_drop_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ===== sim/tb_note_off_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// tb_note_off_scheduler_core - self-checking bench for the note-off scheduler
// Drives event, advance, locate and unused-mode words through the command
// channel. A table model built into the bench predicts every note-off and
// drop word, and the predictions are checked in order against the strobed
// results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_note_off_scheduler_core;
  import nos_pkg::*;

  localparam int CYCLE_LIMIT  = 250000;
  // long enough for an advance over a full table, with margin on top
  localparam int DRAIN_CYCLES = CAPACITY + 12;
  localparam int MAX_REPORTS  = 40;

  // one expected result word
  typedef struct {
    logic [63:0] due_tick;
    logic [31:0] sink;
    logic [7:0]  chan;
    logic [7:0]  note;
    logic [7:0]  tag;
    logic [6:0]  vel;
    logic        dropped;
    logic        last;
  } off_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [63:0] in_tick;
  logic [7:0]  in_payload_tag;
  logic [31:0] in_duration;
  logic [31:0] in_sink_id;
  logic [7:0]  in_note;
  logic [7:0]  in_channel;
  logic        out_valid;
  logic [63:0] out_due_tick;
  logic [31:0] out_off_sink;
  logic [7:0]  out_off_channel;
  logic [7:0]  out_off_note;
  logic [7:0]  out_off_tag;
  logic [6:0]  out_velocity;
  logic        out_dropped;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_idx_t    cfg_index;
  logic [7:0]  cfg_data;

  // bench copy of the pending note-off table and the code registers
  logic [63:0] tbl_time [CAPACITY];
  logic [31:0] tbl_sink [CAPACITY];
  logic [7:0]  tbl_note [CAPACITY];
  logic [7:0]  tbl_chan [CAPACITY];
  int          tbl_fill;
  logic [7:0]  on_code;
  logic [7:0]  off_code;

  off_word_t   expected_offs[$];   // note-off / drop words still to come
  int          err_count;
  int          cycle_count;
  int          live_items;         // words the block actually acts on
  logic [63:0] song_pos;           // running position for musical phrases
  bit          no_gaps;

  note_off_scheduler_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_tick         (in_tick),
    .in_payload_tag  (in_payload_tag),
    .in_duration     (in_duration),
    .in_sink_id      (in_sink_id),
    .in_note         (in_note),
    .in_channel      (in_channel),
    .out_valid       (out_valid),
    .out_due_tick    (out_due_tick),
    .out_off_sink    (out_off_sink),
    .out_off_channel (out_off_channel),
    .out_off_note    (out_off_note),
    .out_off_tag     (out_off_tag),
    .out_velocity    (out_velocity),
    .out_dropped     (out_dropped),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[note_off_scheduler_core] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_count < MAX_REPORTS)
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Table model: applies one accepted word and queues the words it causes.
  task automatic schedule_offs(mode_t m, logic [63:0] t, logic [7:0] tag,
                               logic [31:0] dur, logic [31:0] sink,
                               logic [7:0] note, logic [7:0] chan);
    logic [63:0] due;
    int          keep;
    int          n_due;
    int          n_out;
    off_word_t   w;
    due = t + {32'd0, dur};   // wraps mod 2^64
    keep = 0;
    n_due = 0;
    n_out = 0;
    case (m)
      MODE_EVENT: begin
        if (tag == on_code && dur != 32'd0) begin
          live_items++;
          if (tbl_fill >= CAPACITY) begin
            // table full: the note is lost and reported with zero tag/velocity
            w = '{due, sink, chan, note, 8'd0, 7'd0, 1'b1, 1'b1};
            expected_offs.insert(expected_offs.size(), w);
          end else begin
            tbl_time[tbl_fill] = due;
            tbl_sink[tbl_fill] = sink;
            tbl_note[tbl_fill] = note;
            tbl_chan[tbl_fill] = chan;
            tbl_fill++;
          end
        end
      end
      MODE_ADVANCE: begin
        live_items++;
        for (int i = 0; i < tbl_fill; i++)
          if (tbl_time[i] <= t) n_due++;
        // emit due entries in table order, compact the rest in place
        for (int i = 0; i < tbl_fill; i++) begin
          if (tbl_time[i] <= t) begin
            n_out++;
            w = '{tbl_time[i], tbl_sink[i], tbl_chan[i], tbl_note[i],
                  off_code, RELEASE_VEL, 1'b0, n_out == n_due};
            expected_offs.insert(expected_offs.size(), w);
          end else begin
            tbl_time[keep] = tbl_time[i];
            tbl_sink[keep] = tbl_sink[i];
            tbl_note[keep] = tbl_note[i];
            tbl_chan[keep] = tbl_chan[i];
            keep++;
          end
        end
        tbl_fill = keep;
      end
      MODE_LOCATE: begin
        live_items++;
        tbl_fill = 0;
      end
      default: ;
    endcase
  endtask

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one command word and hold it until busy lets it in.
  task automatic send_word(mode_t m, logic [63:0] t, logic [7:0] tag,
                           logic [31:0] dur, logic [31:0] sink,
                           logic [7:0] note, logic [7:0] chan);
    int gap;
    in_mode        <= m;
    in_tick        <= t;
    in_payload_tag <= tag;
    in_duration    <= dur;
    in_sink_id     <= sink;
    in_note        <= note;
    in_channel     <= chan;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    schedule_offs(m, t, tag, dur, sink, note, chan);
    gap = no_gaps ? 0 : pick_gap();
    // start stays high when the next word follows at once
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every queued word to come out.
  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_offs.size() != 0) @(posedge clk);
  endtask

  // Idle the block fully; events and locates give no word to wait for.
  task automatic quiesce();
    hold_until_drained();
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    quiesce();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NOTE_ON:  on_code  = val;
      CFG_NOTE_OFF: off_code = val;
      default: ;
    endcase
  endtask

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin : check_offs
    off_word_t want;
    if (rst_n && out_valid) begin
      if (expected_offs.size() == 0) begin
        report_mismatch("unexpected word (off time)", out_due_tick, 64'd0);
      end else begin
        want = expected_offs.pop_front();
        check_field("off time", out_due_tick, want.due_tick);
        check_field("off_sink", out_off_sink, want.sink);
        check_field("off_channel", out_off_channel, want.chan);
        check_field("off_note", out_off_note, want.note);
        check_field("off_tag", out_off_tag, want.tag);
        check_field("velocity", out_velocity, want.vel);
        check_field("dropped", out_dropped, want.dropped);
        check_field("last", out_last, want.last);
      end
    end
  end

  // Reset codes: note-on tag 1, off time boundary, filtered events.
  task automatic test_default_codes();
    send_word(MODE_EVENT, 64'd100, 8'd1, 32'd5, 32'h0, 8'h00, 8'h00);
    send_word(MODE_EVENT, 64'd100, 8'd2, 32'd5, 32'h1, 8'h01, 8'h01); // not a note-on
    send_word(MODE_EVENT, 64'd100, 8'd1, 32'd0, 32'h2, 8'h02, 8'h02); // zero length
    send_word(MODE_ADVANCE, 64'd104, 8'd0, 32'd0, 32'h0, 8'h00, 8'h00); // nothing due
    hold_until_drained();
    send_word(MODE_ADVANCE, 64'd105, 8'd0, 32'd0, 32'h0, 8'h00, 8'h00); // due exactly
  endtask

  // Fill all slots with edge values, overflow once, then flush everything.
  task automatic test_full_table();
    logic [63:0] t;
    logic [31:0] d;
    logic [31:0] s;
    for (int i = 0; i <= CAPACITY; i++) begin
      case (i)
        0:       begin t = '1;   d = 32'd1; s = '1;    end  // wraps to zero
        1:       begin t = '1;   d = '1;    s = 32'd0; end  // wraps high
        2:       begin t = '0;   d = '1;    s = 32'hA5A5_5A5A; end
        default: begin t = 64'd1000 + i; d = i; s = $urandom; end
      endcase
      send_word(MODE_EVENT, t, on_code, d, s, (i == 0) ? 8'hFF : 8'(i),
                (i == 1) ? 8'hFF : 8'(i));
    end
    send_word(MODE_ADVANCE, '1, 8'd0, 32'd0, 32'h0, 8'h00, 8'h00);
  endtask

  // Locate empties the table; the spare mode code is ignored.
  task automatic test_locate_and_unused();
    send_word(MODE_EVENT, 64'd0, on_code, 32'd10, 32'h1234, 8'd60, 8'd3);
    send_word(MODE_UNUSED, '1, on_code, '1, '1, 8'hFF, 8'hFF);
    send_word(MODE_LOCATE, 64'd0, 8'd0, 32'd0, 32'h0, 8'h00, 8'h00);
    send_word(MODE_ADVANCE, '1, 8'd0, 32'd0, 32'h0, 8'h00, 8'h00);
  endtask

  // One phrase: a run of notes with some noise, then an advance.
  task automatic play_phrase();
    int          notes;
    int          r;
    logic [31:0] d;
    notes = $urandom_range(1, 20);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < notes; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        d = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 48));
        if (d == 32'd0) d = 32'd1;
        send_word(MODE_EVENT, song_pos, on_code, d, $urandom,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        song_pos = song_pos + $urandom_range(0, 6);
      end else begin
        send_word(mode_t'(2'($urandom_range(0, 3))), {$urandom, $urandom},
                  8'($urandom_range(0, 255)), $urandom_range(0, 1) ? 32'd0 : $urandom,
                  $urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    song_pos = song_pos + $urandom_range(0, 40);
    send_word(MODE_ADVANCE, song_pos, 8'($urandom_range(0, 255)), $urandom, $urandom,
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    no_gaps = 1'b0;
    if ($urandom_range(0, 9) == 0) hold_until_drained();
  endtask

  // Random phrases under one pair of codes.
  task automatic test_random_phrases(logic [7:0] on_val, logic [7:0] off_val, int count);
    int target;
    write_reg(CFG_NOTE_ON, on_val);
    write_reg(CFG_NOTE_OFF, off_val);
    case ($urandom_range(0, 2))
      0:       song_pos = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 300); // near wrap
      1:       song_pos = {$urandom, $urandom};
      default: song_pos = 64'($urandom_range(0, 1000));
    endcase
    target = live_items + count;
    while (live_items < target) play_phrase();
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_mode        <= MODE_EVENT;
    in_tick        <= '0;
    in_payload_tag <= '0;
    in_duration    <= '0;
    in_sink_id     <= '0;
    in_note        <= '0;
    in_channel     <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_NOTE_ON;
    cfg_data       <= '0;
    cycle_count    = 0;
    err_count      = 0;
    live_items     = 0;
    tbl_fill       = 0;
    on_code        = NOTE_ON_RST;
    off_code       = NOTE_OFF_RST;
    song_pos       = '0;
    no_gaps        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_codes();
    test_full_table();
    test_locate_and_unused();
    test_random_phrases(8'h00, 8'hFF, 28);
    test_random_phrases(8'hFF, 8'h00, 28);
    test_random_phrases(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 28);
    test_random_phrases(NOTE_ON_RST, NOTE_OFF_RST, 28);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[note_off_scheduler_core] OK");
    end else begin
      $display("[note_off_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
